// ----- hw/rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants, payload structs and stage types of the rgb to hsv core.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS   = 8;
    localparam int CHAN_MAX       = (1 << CHANNEL_BITS) - 1;

    localparam int PIX_W          = CHANNEL_BITS;
    localparam int HUE_W          = 13;
    localparam int SAT_W          = CHANNEL_BITS;
    localparam int VAL_W          = CHANNEL_BITS;

    localparam int HUE_PER_SECTOR = 960;
    localparam int HUE_FULL       = 5760;
    localparam int HUE_CALC_W     = 14;

    localparam int DIV_STEPS      = (CHANNEL_BITS > 10) ? CHANNEL_BITS : 10;
    localparam int DIV_LAST       = DIV_STEPS - 1;
    localparam int DIV_W          = CHANNEL_BITS + DIV_STEPS;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [DIV_W-1:0]        t_div;
    typedef logic [DIV_STEPS-1:0]    t_quo;
    typedef logic [HUE_CALC_W-1:0]   t_hcalc;
    typedef logic [HUE_W-1:0]        t_hue;
    typedef logic [SAT_W-1:0]        t_sat;
    typedef logic [VAL_W-1:0]        t_val;
    typedef logic [QUEUE_AW-1:0]     t_qptr;
    typedef logic [QUEUE_AW:0]       t_qcnt;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_hue hue;
        t_sat saturation;
        t_val value;
    } t_hsv;

    typedef struct packed {
        t_sector sector;
        logic    neg;
        logic    zero;
        t_chan   maxv;
        t_chan   delta;
        t_div    hue_rem;
        t_div    sat_rem;
    } t_work;

    typedef struct packed {
        t_work w;
        t_quo  hue_q;
        t_quo  sat_q;
    } t_stage;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// RGB to HSV pixel converter with hue in sixteenths of a degree.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while empty is high or pop is set; the rate
//   is set by the divider pipeline that retires one quotient bit of hue and
//   saturation per stage over 10 stages
// reset: synchronous, active low; clears queue pointers and stage valid bits,
//   no clearing pass, push is taken in the first cycle after reset
`default_nettype none

module rgb_to_hsv_converter_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire rhc_pkg::t_pixel i_pixel,
    output logic                 empty,
    input  wire logic            pop,
    output rhc_pkg::t_hsv        o_hsv
);

    rhc_pkg::t_q_status q_status;
    rhc_pkg::t_work     wr_work;
    rhc_pkg::t_work     rd_work;
    logic               wr_en;
    logic               rd_en;

    assign full = q_status.full;

    rhc_front u_front (
        .i_push     (push),
        .i_pixel    (i_pixel),
        .i_q_status (q_status),
        .o_wr_en    (wr_en),
        .o_work     (wr_work)
    );

    rhc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_work),
        .i_rd_en   (rd_en),
        .o_rd_data (rd_work),
        .o_status  (q_status)
    );

    rhc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_work     (rd_work),
        .i_q_status (q_status),
        .o_rd_en    (rd_en),
        .pop        (pop),
        .empty      (empty),
        .o_hsv      (o_hsv)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_front.sv -----
// ----------------------------------------------------------------------------
// rhc_front
// Accepts a pixel, finds max, min and sector, and builds the two dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
    input  wire logic               i_push,
    input  wire rhc_pkg::t_pixel    i_pixel,
    input  wire rhc_pkg::t_q_status i_q_status,
    output logic                    o_wr_en,
    output rhc_pkg::t_work          o_work
);

    rhc_pkg::t_chan                   r_ch;
    rhc_pkg::t_chan                   g_ch;
    rhc_pkg::t_chan                   b_ch;
    rhc_pkg::t_chan                   hi;
    rhc_pkg::t_chan                   lo;
    rhc_pkg::t_chan                   delta;
    rhc_pkg::t_chan                   mag;
    rhc_pkg::t_sector                 sector;
    logic [rhc_pkg::CHANNEL_BITS:0]   diff;
    logic [rhc_pkg::CHANNEL_BITS:0]   mag_w;

    assign o_wr_en = i_push && !i_q_status.full;

    always_comb begin
        r_ch = rhc_pkg::t_chan'(i_pixel.red);
        g_ch = rhc_pkg::t_chan'(i_pixel.green);
        b_ch = rhc_pkg::t_chan'(i_pixel.blue);

        hi = r_ch;
        if (g_ch > hi) hi = g_ch;
        if (b_ch > hi) hi = b_ch;
        lo = r_ch;
        if (g_ch < lo) lo = g_ch;
        if (b_ch < lo) lo = b_ch;
        delta = hi - lo;

        // red wins ties over green, green over blue
        if (r_ch == hi) begin
            sector = rhc_pkg::SEC_RED;
            diff   = {1'b0, g_ch} - {1'b0, b_ch};
        end else if (g_ch == hi) begin
            sector = rhc_pkg::SEC_GREEN;
            diff   = {1'b0, b_ch} - {1'b0, r_ch};
        end else begin
            sector = rhc_pkg::SEC_BLUE;
            diff   = {1'b0, r_ch} - {1'b0, g_ch};
        end

        mag_w = diff[rhc_pkg::CHANNEL_BITS] ? (~diff + 1'b1) : diff;
        mag   = mag_w[rhc_pkg::CHANNEL_BITS-1:0];

        o_work.sector  = sector;
        o_work.neg     = diff[rhc_pkg::CHANNEL_BITS];
        o_work.zero    = (delta == '0);
        o_work.maxv    = hi;
        o_work.delta   = delta;
        o_work.hue_rem = rhc_pkg::t_div'(mag) * rhc_pkg::t_div'(rhc_pkg::HUE_PER_SECTOR);
        o_work.sat_rem = rhc_pkg::t_div'(delta) * rhc_pkg::t_div'(rhc_pkg::CHAN_MAX);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_queue.sv -----
// ----------------------------------------------------------------------------
// rhc_queue
// Short first-in first-out queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire rhc_pkg::t_work     i_wr_data,
    input  wire logic               i_rd_en,
    output rhc_pkg::t_work          o_rd_data,
    output rhc_pkg::t_q_status      o_status
);

    rhc_pkg::t_work r_mem [rhc_pkg::QUEUE_DEPTH];
    rhc_pkg::t_qptr r_wr_ptr;
    rhc_pkg::t_qptr r_rd_ptr;
    rhc_pkg::t_qcnt r_count;
    rhc_pkg::t_qcnt n_count;

    assign o_rd_data       = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == rhc_pkg::t_qcnt'(rhc_pkg::QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        case ({i_wr_en, i_rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rhc_pkg::t_qcnt'(rhc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && o_status.full && !i_rd_en))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && o_status.empty))
        else $error("read from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_back.sv -----
// ----------------------------------------------------------------------------
// rhc_back
// Pipelined restoring dividers for hue and saturation, one quotient bit per
// stage, then hue sector offset and wrap, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rhc_pkg::t_work     i_work,
    input  wire rhc_pkg::t_q_status i_q_status,
    output logic                    o_rd_en,
    input  wire logic               pop,
    output logic                    empty,
    output rhc_pkg::t_hsv           o_hsv
);

    function automatic rhc_pkg::t_stage div_step(rhc_pkg::t_stage s, int unsigned k);
        rhc_pkg::t_div   hd;
        rhc_pkg::t_div   sd;
        rhc_pkg::t_stage n;
        n  = s;
        hd = rhc_pkg::t_div'(s.w.delta) << k;
        sd = rhc_pkg::t_div'(s.w.maxv) << k;
        if (s.w.hue_rem >= hd) begin
            n.w.hue_rem = s.w.hue_rem - hd;
            n.hue_q     = {s.hue_q[rhc_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
            n.hue_q     = {s.hue_q[rhc_pkg::DIV_STEPS-2:0], 1'b0};
        end
        if (s.w.sat_rem >= sd) begin
            n.w.sat_rem = s.w.sat_rem - sd;
            n.sat_q     = {s.sat_q[rhc_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
            n.sat_q     = {s.sat_q[rhc_pkg::DIV_STEPS-2:0], 1'b0};
        end
        return n;
    endfunction

    logic                   advance;
    rhc_pkg::t_stage        src0;
    rhc_pkg::t_stage        r_stg [rhc_pkg::DIV_STEPS];
    rhc_pkg::t_stage        n_stg [rhc_pkg::DIV_STEPS];
    logic                   r_vld [rhc_pkg::DIV_STEPS];
    logic                   r_out_vld;
    rhc_pkg::t_hsv          r_out;
    rhc_pkg::t_hsv          n_out;
    rhc_pkg::t_hcalc        base;
    rhc_pkg::t_hcalc        mag;
    rhc_pkg::t_hcalc        hsum;

    assign advance = !r_out_vld || pop;
    assign o_rd_en = advance && !i_q_status.empty;
    assign empty   = !r_out_vld;
    assign o_hsv   = r_out;

    always_comb begin
        src0.w     = i_work;
        src0.hue_q = '0;
        src0.sat_q = '0;
    end

    for (genvar gi = 0; gi < rhc_pkg::DIV_STEPS; gi++) begin : g_stage
        if (gi == 0) begin : g_first
            assign n_stg[gi] = div_step(src0, rhc_pkg::DIV_STEPS - 1);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi] <= 1'b0;
                end else if (advance) begin
                    r_vld[gi] <= !i_q_status.empty;
                end
            end
        end else begin : g_next
            assign n_stg[gi] = div_step(r_stg[gi-1], rhc_pkg::DIV_STEPS - 1 - gi);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi] <= 1'b0;
                end else if (advance) begin
                    r_vld[gi] <= r_vld[gi-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_stg[gi] <= n_stg[gi];
            end
        end
    end

    // floor on negative angles, then wrap into one turn
    always_comb begin
        case (r_stg[rhc_pkg::DIV_LAST].w.sector)
            rhc_pkg::SEC_RED:   base = rhc_pkg::t_hcalc'(rhc_pkg::HUE_FULL);
            rhc_pkg::SEC_GREEN: base = rhc_pkg::t_hcalc'(2 * rhc_pkg::HUE_PER_SECTOR);
            rhc_pkg::SEC_BLUE:  base = rhc_pkg::t_hcalc'(4 * rhc_pkg::HUE_PER_SECTOR);
            default:            base = '0;
        endcase
        mag = rhc_pkg::t_hcalc'(r_stg[rhc_pkg::DIV_LAST].hue_q)
            + rhc_pkg::t_hcalc'(r_stg[rhc_pkg::DIV_LAST].w.neg
                                && (r_stg[rhc_pkg::DIV_LAST].w.hue_rem != '0));
        hsum = r_stg[rhc_pkg::DIV_LAST].w.neg ? (base - mag) : (base + mag);
        if (hsum >= rhc_pkg::t_hcalc'(rhc_pkg::HUE_FULL)) begin
            hsum = hsum - rhc_pkg::t_hcalc'(rhc_pkg::HUE_FULL);
        end

        n_out.value = rhc_pkg::t_val'(r_stg[rhc_pkg::DIV_LAST].w.maxv);
        if (r_stg[rhc_pkg::DIV_LAST].w.zero) begin
            n_out.hue        = '0;
            n_out.saturation = '0;
        end else begin
            n_out.hue        = rhc_pkg::t_hue'(hsum);
            n_out.saturation = rhc_pkg::t_sat'(r_stg[rhc_pkg::DIV_LAST].sat_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_vld[rhc_pkg::DIV_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_hsv.hue < rhc_pkg::t_hue'(rhc_pkg::HUE_FULL)))
        else $error("hue out of range");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_hsv.saturation == '0)) |-> (o_hsv.hue == '0))
        else $error("grey pixel with nonzero hue");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_vld[rhc_pkg::DIV_LAST]) |=> r_out_vld)
        else $error("finished item lost before result register");

endmodule

`default_nettype wire
